@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and default sizes of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_FRONT = 3'd4,
        OP_READ_BACK  = 3'd5,
        OP_READ_INDEX = 3'd6,
        OP_CLEAR      = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

@@ rtl/double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of data words in a circular RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_valid / o_stall with i_op, i_value, i_index. A request
//   transfers at a clock edge with i_valid high and o_stall low.
//   Result channel: o_valid / i_stall with o_data_out, o_status, o_occupancy.
//   Every request yields exactly one result.
//   Results: push, clear and every refused request give their result from
//   the result register alone; pops and reads that hit a live entry pass
//   through the registered RAM read and then the result register.
//   One request per cycle for push, clear and refused requests while i_stall
//   is low; a successful pop or read raises o_stall until its RAM read is
//   done, so no new request is taken before its result is registered.
//   The result register holds its value while i_stall is high; a new
//   request is taken in the same cycle the waiting result transfers.
//   Reset (synchronous, active low) empties the queue and sets the head to
//   zero. RAM contents are not cleared; only live entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [deq_pkg::OP_W-1:0]      i_op,
    input  logic [deq_pkg::VALUE_W-1:0]   i_value,
    input  logic [deq_pkg::INDEX_W-1:0]   i_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [deq_pkg::VALUE_W-1:0]   o_data_out,
    output logic [deq_pkg::STATUS_W-1:0]  o_status,
    output logic [deq_pkg::OCC_W-1:0]     o_occupancy
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_data_out;
    t_status               r_status;
    logic [OCC_W-1:0]      r_occupancy;

    logic [AW-1:0]         n_head;
    logic [CW-1:0]         n_count;

    logic                  accept;
    t_op                   op;
    logic                  full;
    logic                  empty;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic [AW-1:0]         back_slot;
    logic [AW-1:0]         last_slot;
    logic [AW-1:0]         idx_slot;
    logic                  wr_req;
    logic                  rd_req;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    t_status               res_status;
    logic [DATA_WIDTH-1:0] rdata;

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
        logic [SW-1:0] adj;
        adj = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
        return adj[AW-1:0];
    endfunction

    assign o_stall     = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign accept      = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_occupancy = r_occupancy;

    always_comb begin
        op        = t_op'(i_op);
        full      = (r_count == CW'(DEPTH));
        empty     = (r_count == '0);
        head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : (r_head - 1'b1);
        head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : (r_head + 1'b1);
        back_slot = wrap(SW'(r_head) + SW'(r_count));
        last_slot = wrap(SW'(r_head) + SW'(r_count - 1'b1));
        idx_slot  = wrap(SW'(r_head) + SW'(i_index));

        n_head     = r_head;
        n_count    = r_count;
        wr_req     = 1'b0;
        rd_req     = 1'b0;
        waddr      = back_slot;
        raddr      = r_head;
        res_status = ST_OK;

        case (op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    wr_req  = 1'b1;
                    waddr   = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    wr_req  = 1'b1;
                    waddr   = back_slot;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_req  = 1'b1;
                    raddr   = r_head;
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_req  = 1'b1;
                    raddr   = last_slot;
                    n_count = r_count - 1'b1;
                end
            end
            OP_READ_FRONT: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_req = 1'b1;
                    raddr  = r_head;
                end
            end
            OP_READ_BACK: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_req = 1'b1;
                    raddr  = last_slot;
                end
            end
            OP_READ_INDEX: begin
                if (IW'(i_index) >= IW'(r_count)) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_req = 1'b1;
                    raddr  = idx_slot;
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && wr_req),
        .i_waddr (waddr),
        .i_wdata (DATA_WIDTH'(i_value)),
        .i_re    (accept && rd_req),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_head  <= n_head;
                        r_count <= n_count;
                        if (rd_req) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_READ;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_data_out  <= '0;
                            r_status    <= res_status;
                            r_occupancy <= OCC_W'(n_count);
                        end
                    end else if (r_out_valid && !i_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_data_out  <= VALUE_W'(rdata);
                    r_status    <= ST_OK;
                    r_occupancy <= OCC_W'(r_count);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
